>>> hdl/tbms_pkg.sv
// package: shared types, constants and mask tables for terrain blend mask select
`default_nettype none
package tbms_pkg;
    localparam int TERRAIN_ID_BITS = 8;
    localparam int PRIORITY_BITS   = 8;
    localparam int NDIR            = 8;

    localparam logic [1:0] KIND_BASE  = 2'd0;
    localparam logic [1:0] KIND_ADJ   = 2'd1;
    localparam logic [1:0] KIND_DIAG  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic REG_BLEND_EN = 1'b0;
    localparam logic REG_TCOUNT   = 1'b1;

    localparam logic [4:0] NO_ADJ = 5'd31;

    typedef struct packed {
        logic       base_valid;
        logic [7:0] base_terrain;
        logic [7:0] tile_priority;
        logic [63:0] neighbor_terrains;
        logic [63:0] neighbor_priorities;
        logic [7:0] neighbor_present;
        logic [1:0] position_phase;
    } tbms_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] terrain;
        logic [4:0] mask_index;
        logic       last;
    } tbms_out_t;

    // one sorted influence group
    typedef struct packed {
        logic [TERRAIN_ID_BITS-1:0] terr;
        logic [NDIR-1:0]            dirs;
    } tbms_group_t;

    // classified tile handed from front to back
    typedef struct packed {
        logic                       err;
        logic [TERRAIN_ID_BITS-1:0] bterr;
        logic [1:0]                 phase;
        logic [3:0]                 ngroups;
        tbms_group_t [NDIR-1:0]     groups;
    } tbms_job_t;

    function automatic logic [4:0] adj_lookup(input logic [3:0] idx);
        logic [4:0] m;
        case (idx)
            4'd0:  m = NO_ADJ;
            4'd1:  m = 5'd4;
            4'd2:  m = 5'd0;
            4'd3:  m = 5'd25;
            4'd4:  m = 5'd8;
            4'd5:  m = 5'd20;
            4'd6:  m = 5'd24;
            4'd7:  m = 5'd26;
            4'd8:  m = 5'd12;
            4'd9:  m = 5'd23;
            4'd10: m = 5'd21;
            4'd11: m = 5'd29;
            4'd12: m = 5'd22;
            4'd13: m = 5'd28;
            4'd14: m = 5'd27;
            default: m = 5'd30;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] diag_lookup(input logic [1:0] j);
        logic [4:0] m;
        case (j)
            2'd0: m = 5'd18;
            2'd1: m = 5'd16;
            2'd2: m = 5'd17;
            default: m = 5'd19;
        endcase
        return m;
    endfunction
endpackage
`default_nettype wire

>>> hdl/tbms_if.sv
// interfaces: valid/ready channels for tiles and draw results
`default_nettype none
interface tbms_in_if;
    import tbms_pkg::*;
    logic     valid;
    logic     ready;
    tbms_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface tbms_out_if;
    import tbms_pkg::*;
    logic      valid;
    logic      ready;
    tbms_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/terrain_blend_mask_select.sv
// top level: config registers, front classifier, job queue and result sequencer
//
//  channel | dir | transfer rule              | payload
//  tile    | in  | tile.valid & tile.ready    | tbms_in_t
//  res     | out | res.valid & res.ready      | tbms_out_t
//  apb     | in  | psel&penable&pwrite&pready | blend enable, terrain_count
//
// a present tile gives 1 to 9 results, one per cycle from the back sequencer unless
// res stalls, so a tile occupies the back until its last result is sent; the front
// takes one tile per cycle, two pipeline stages deep, while the queue has room
// a tile's path to its first result: both front stages, queue, output register
// reset: asynchronous, active low; blend enable=1, terrain_count=32
// either side may stall; the queue and output register hold their contents
`default_nettype none
module terrain_blend_mask_select
    import tbms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    tbms_in_if.sink          tile,
    tbms_out_if.source       res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic       blend_en_reg;
    logic [8:0] tcount_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_en_reg <= 1'b1;
            tcount_reg   <= 9'd32;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            case (reg_sel)
                REG_BLEND_EN: blend_en_reg <= pwdata[0];
                REG_TCOUNT:   tcount_reg   <= pwdata[8:0];
                default:      blend_en_reg <= blend_en_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BLEND_EN: prdata = {31'd0, blend_en_reg};
            REG_TCOUNT:   prdata = {23'd0, tcount_reg};
            default:      prdata = 32'd0;
        endcase
    end

    logic      f_valid, f_ready, q_valid, q_ready;
    tbms_job_t f_job, q_job;

    tbms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tile      (tile),
        .blend_en  (blend_en_reg),
        .tcount    (tcount_reg),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    tbms_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_job)
    );

    tbms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .res       (res)
    );

    // error and base results always close or open a tile
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.payload.kind == KIND_ERROR |-> res.payload.last)
        else $error("error result without last");
    a_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.payload.kind == KIND_BASE || res.payload.kind == KIND_ERROR)
        |-> res.payload.mask_index == 5'd0)
        else $error("base or error result carries a mask");
    a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> q_valid)
        else $error("queue popped while empty");
endmodule
`default_nettype wire

>>> hdl/tbms_front.sv
// front: accept a tile, group influences by terrain and sort them by priority
`default_nettype none
module tbms_front
    import tbms_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    tbms_in_if.sink        tile,
    input  wire logic      blend_en,
    input  wire logic [8:0] tcount,
    output logic           job_valid,
    input  wire logic      job_ready,
    output tbms_job_t      job
);
    // stage 1 registers: per-direction influence and group membership
    logic                           s1_valid_reg;
    logic                           s1_err_reg;
    logic [TERRAIN_ID_BITS-1:0]     s1_bterr_reg;
    logic [1:0]                     s1_phase_reg;
    logic [NDIR-1:0]                s1_leader_reg;   // first direction of its terrain
    logic [NDIR-1:0][NDIR-1:0]      s1_member_reg;   // [leader][dir]
    logic [NDIR-1:0][TERRAIN_ID_BITS-1:0] s1_terr_reg;
    logic [NDIR-1:0][PRIORITY_BITS-1:0]   s1_prio_reg;

    logic s2_valid_reg;
    tbms_job_t s2_job_reg;

    logic s1_adv, s2_adv;
    assign s2_adv = !s2_valid_reg || job_ready;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign tile.ready = s1_adv;

    logic [NDIR-1:0] infl;
    logic [NDIR-1:0][TERRAIN_ID_BITS-1:0] nt;
    logic [NDIR-1:0][PRIORITY_BITS-1:0] np;
    logic [NDIR-1:0] leader_next;
    logic [NDIR-1:0][NDIR-1:0] member_next;
    logic [NDIR-1:0][PRIORITY_BITS-1:0] gprio_next;

    always_comb
    begin
        for (int k = 0; k < NDIR; k++)
        begin
            nt[k] = tile.payload.neighbor_terrains[8*k +: TERRAIN_ID_BITS];
            np[k] = tile.payload.neighbor_priorities[8*k +: PRIORITY_BITS];
            infl[k] = tile.payload.neighbor_present[k] && blend_en
                && ({1'b0, nt[k]} < tcount)
                && (nt[k] != tile.payload.base_terrain[TERRAIN_ID_BITS-1:0])
                && (np[k] > tile.payload.tile_priority[PRIORITY_BITS-1:0]);
        end
        for (int k = 0; k < NDIR; k++)
        begin
            leader_next[k] = infl[k];
            for (int j = 0; j < NDIR; j++)
            begin
                if (j < k && infl[j] && nt[j] == nt[k])
                    leader_next[k] = 1'b0;
                member_next[k][j] = infl[k] && infl[j] && (nt[j] == nt[k]) && (j >= k);
            end
        end
        // group priority is the one of its highest-direction member
        for (int k = 0; k < NDIR; k++)
        begin
            gprio_next[k] = np[k];
            for (int j = 0; j < NDIR; j++)
                if (member_next[k][j])
                    gprio_next[k] = np[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_adv)
            s1_valid_reg <= tile.valid && tile.payload.base_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_err_reg    <= {1'b0, tile.payload.base_terrain[TERRAIN_ID_BITS-1:0]} >= tcount;
            s1_bterr_reg  <= tile.payload.base_terrain[TERRAIN_ID_BITS-1:0];
            s1_phase_reg  <= tile.payload.position_phase;
            s1_leader_reg <= leader_next;
            s1_member_reg <= member_next;
            s1_terr_reg   <= nt;
            s1_prio_reg   <= gprio_next;
        end
    end

    // stage 2: rank each group (stable ascending) and place it
    tbms_job_t job_next;
    logic [NDIR-1:0][2:0] rank;
    always_comb
    begin
        job_next = '0;
        job_next.err = s1_err_reg;
        job_next.bterr = s1_bterr_reg;
        job_next.phase = s1_phase_reg;
        job_next.ngroups = 4'($countones(s1_leader_reg));
        for (int k = 0; k < NDIR; k++)
        begin
            rank[k] = '0;
            for (int j = 0; j < NDIR; j++)
                if (s1_leader_reg[j] && j != k &&
                    (s1_prio_reg[j] < s1_prio_reg[k] ||
                     (s1_prio_reg[j] == s1_prio_reg[k] && j < k)))
                    rank[k] = rank[k] + 3'd1;
        end
        for (int r = 0; r < NDIR; r++)
            for (int k = 0; k < NDIR; k++)
                if (s1_leader_reg[k] && rank[k] == 3'(r))
                begin
                    job_next.groups[r].terr = s1_terr_reg[k];
                    job_next.groups[r].dirs = s1_member_reg[k];
                end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
            s2_job_reg <= job_next;
    end

    assign job_valid = s2_valid_reg;
    assign job = s2_job_reg;
endmodule
`default_nettype wire

>>> hdl/tbms_queue.sv
// two-entry queue between front and back
`default_nettype none
module tbms_queue
    import tbms_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    input  tbms_job_t  wr_data,
    output logic       rd_valid,
    input  wire logic  rd_ready,
    output tbms_job_t  rd_data
);
    tbms_job_t mem_reg [2];
    logic      wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic wr, rd;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wptr_reg <= !wptr_reg;
            if (rd)
                rptr_reg <= !rptr_reg;
            count_reg <= count_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

>>> hdl/tbms_back.sv
// back: walk the sorted groups and emit one draw result per cycle unless res stalls
`default_nettype none
module tbms_back
    import tbms_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  job_valid,
    output logic       job_ready,
    input  tbms_job_t  job,
    tbms_out_if.source res
);
    typedef enum logic [2:0] {
        ST_BASE  = 3'b001,
        ST_GROUP = 3'b010,
        ST_DIAG  = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] gidx_reg, gidx_next;
    logic [3:0] dleft_reg, dleft_next;   // diagonals still to emit for this group
    logic       out_valid_reg;
    tbms_out_t  out_reg;

    logic        can_load;
    logic        emit;
    tbms_out_t   item;
    logic        item_done;   // job finished after this item
    tbms_group_t g;
    logic [3:0]  aidx;
    logic [4:0]  am;
    logic [3:0]  diags;
    logic [1:0]  dsel;
    logic        have_next_group;

    assign can_load = !out_valid_reg || res.ready;
    assign g = job.groups[gidx_reg];
    assign aidx = {g.dirs[7], g.dirs[5], g.dirs[3], g.dirs[1]};
    assign am = adj_lookup(aidx);

    always_comb
    begin
        diags = (state_reg == ST_DIAG) ? dleft_reg : {g.dirs[6], g.dirs[4], g.dirs[2], g.dirs[0]};
        dsel = 2'd0;
        for (int j = 3; j >= 0; j--)
            if (diags[j])
                dsel = 2'(j);
    end

    assign have_next_group = ({1'b0, gidx_reg} + 4'd1) < job.ngroups;

    always_comb
    begin
        state_next = state_reg;
        gidx_next = gidx_reg;
        dleft_next = dleft_reg;
        item = '0;
        item_done = 1'b0;
        emit = job_valid && can_load;
        item.terrain = g.terr;
        case (state_reg)
            ST_BASE:
            begin
                item.terrain = job.bterr;
                item.kind = job.err ? KIND_ERROR : KIND_BASE;
                item_done = job.err || job.ngroups == 4'd0;
                gidx_next = 3'd0;
                state_next = ST_GROUP;
            end
            ST_GROUP:
            begin
                if (am != NO_ADJ)
                begin
                    item.kind = KIND_ADJ;
                    item.mask_index = (aidx == 4'd1 || aidx == 4'd2 || aidx == 4'd4 ||
                                       aidx == 4'd8) ? am + {3'd0, job.phase} : am;
                    dleft_next = diags;
                end
                else
                begin
                    item.kind = KIND_DIAG;
                    item.mask_index = diag_lookup(dsel);
                    dleft_next = diags & ~(4'd1 << dsel);
                end
                if (dleft_next != 4'd0)
                    state_next = ST_DIAG;
                else if (have_next_group)
                    gidx_next = gidx_reg + 3'd1;
                else
                    item_done = 1'b1;
            end
            ST_DIAG:
            begin
                item.kind = KIND_DIAG;
                item.mask_index = diag_lookup(dsel);
                dleft_next = diags & ~(4'd1 << dsel);
                if (dleft_next == 4'd0)
                begin
                    if (have_next_group)
                    begin
                        gidx_next = gidx_reg + 3'd1;
                        state_next = ST_GROUP;
                    end
                    else
                        item_done = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_BASE;
            end
        endcase
        item.last = item_done;
        if (item_done)
            state_next = ST_BASE;
    end

    assign job_ready = emit && item_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BASE;
            gidx_reg      <= 3'd0;
            dleft_reg     <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                state_reg <= state_next;
                gidx_reg  <= gidx_next;
                dleft_reg <= dleft_next;
            end
            if (can_load)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= item;
    end

    assign res.valid = out_valid_reg;
    assign res.payload = out_reg;
endmodule
`default_nettype wire
